// ===== rtl/core/analog_key_threshold_scanner_top_assert.svh =====
// assertion macros for the analog key threshold scanner checker
`ifndef ANALOG_KEY_THRESHOLD_SCANNER_TOP_ASSERT_SVH
`define ANALOG_KEY_THRESHOLD_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define AKTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define AKTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/akts_pkg.sv =====
// shared types and constants of the analog key threshold scanner
package akts_pkg;

   // key count and field widths
   localparam int KEYS        = 64;
   localparam int KEY_W       = 6;
   localparam int MEM_DEPTH   = 2 ** KEY_W;
   localparam int SAMPLE_W    = 12;
   localparam int PCT_W       = 8;
   localparam int CODE_W      = 8;
   localparam int OP_W        = 2;
   localparam int SPAN_W      = 16;
   localparam int PROD_W      = PCT_W + SPAN_W;
   localparam int CMP_W       = PROD_W + 2;
   localparam int PCT_SCALE   = 100;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // no-key code after reset
   localparam logic [CODE_W-1:0] NO_KEY_RESET = '0;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE   = 2'd0,
      OP_BASELINE = 2'd1,
      OP_CAL      = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RACE_MODE   = 1'b0,
      CSR_NO_KEY_CODE = 1'b1
   } csr_index_type;

   // request held in the table read stage
   typedef struct packed {
      logic                valid;
      op_type              op;
      logic                last;
      logic                in_range;
      logic [SAMPLE_W-1:0] sample;
   } stage_type;

   // per-key calibration read from the tables
   typedef struct packed {
      logic [SAMPLE_W-1:0] baseline;
      logic [SAMPLE_W-1:0] full;
      logic [PCT_W-1:0]    percent;
      logic [CODE_W-1:0]   code;
   } cal_type;

   // control registers
   typedef struct packed {
      logic              race_mode;
      logic [CODE_W-1:0] no_key_code;
   } csr_type;

endpackage

// ===== rtl/core/analog_key_threshold_scanner_top.sv =====
// Analog key threshold scanner: per-key calibration tables and press detection.
// Each request is registered in the table read stage, then its result in the result register.
// Throughput: one request per cycle; the table read register and the result
// register form a two-stage pipe that stalls only while a result is held.
// Reset clears the control registers, the race state and both valid stages;
// the calibration tables are not cleared and must be written before use.
module analog_key_threshold_scanner_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [akts_pkg::OP_W-1:0]          req_op,
   input  logic [akts_pkg::KEY_W-1:0]         req_key_index,
   input  logic [akts_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                               req_last_in_scan,
   input  logic [akts_pkg::SAMPLE_W-1:0]      req_cal_full,
   input  logic [akts_pkg::PCT_W-1:0]         req_cal_percent,
   input  logic [akts_pkg::CODE_W-1:0]        req_cal_code,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [akts_pkg::CODE_W-1:0]        rsp_key_code,
   output logic [akts_pkg::SAMPLE_W-1:0]      rsp_level,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [akts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [akts_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import akts_pkg::*;

   csr_type   csr_ff;
   stage_type stage;
   cal_type   cal;
   logic      advance;

   // pipe moves unless a held result is stalled
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.race_mode   <= 1'b0;
         csr_ff.no_key_code <= NO_KEY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RACE_MODE:   csr_ff.race_mode   <= csr_wdata[0];
            CSR_NO_KEY_CODE: csr_ff.no_key_code <= csr_wdata[CODE_W-1:0];
            default:         csr_ff <= csr_ff;
         endcase
      end
   end

   akts_tables u_tables (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .req_valid        (req_valid),
      .req_op           (op_type'(req_op)),
      .req_key_index    (req_key_index),
      .req_sample       (req_sample),
      .req_last_in_scan (req_last_in_scan),
      .req_cal_full     (req_cal_full),
      .req_cal_percent  (req_cal_percent),
      .req_cal_code     (req_cal_code),
      .stage            (stage),
      .cal              (cal)
   );

   akts_eval u_eval (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .stage        (stage),
      .cal          (cal),
      .csr          (csr_ff),
      .rsp_valid    (rsp_valid),
      .rsp_key_code (rsp_key_code),
      .rsp_level    (rsp_level)
   );

endmodule

// ===== rtl/core/akts_tables.sv =====
// per-key calibration memories and the request stage that reads them
module akts_tables (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           req_valid,
   input  akts_pkg::op_type               req_op,
   input  logic [akts_pkg::KEY_W-1:0]     req_key_index,
   input  logic [akts_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                           req_last_in_scan,
   input  logic [akts_pkg::SAMPLE_W-1:0]  req_cal_full,
   input  logic [akts_pkg::PCT_W-1:0]     req_cal_percent,
   input  logic [akts_pkg::CODE_W-1:0]    req_cal_code,
   output akts_pkg::stage_type            stage,
   output akts_pkg::cal_type              cal
);
   import akts_pkg::*;

   logic [SAMPLE_W-1:0]                       base_mem_ff [MEM_DEPTH];
   logic [SAMPLE_W+PCT_W+CODE_W-1:0]          cal_mem_ff  [MEM_DEPTH];
   logic [SAMPLE_W-1:0]                       base_rd_ff;
   logic [SAMPLE_W+PCT_W+CODE_W-1:0]          cal_rd_ff;
   stage_type                                 stage_ff;
   stage_type                                 stage_in;
   logic                                      accept;
   logic                                      in_range;

   assign accept   = advance && req_valid;
   assign in_range = int'(req_key_index) < KEYS;

   // next stage contents
   always_comb begin
      stage_in.valid    = req_valid;
      stage_in.op       = req_op;
      stage_in.last     = req_last_in_scan;
      stage_in.in_range = in_range;
      stage_in.sample   = req_sample;
   end

   // stage register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   // baseline memory, captured from the sample
   always_ff @(posedge clock) begin
      if (accept && in_range && req_op == OP_BASELINE) begin
         base_mem_ff[req_key_index] <= req_sample;
      end
      if (advance) begin
         base_rd_ff <= base_mem_ff[req_key_index];
      end
   end

   // full-scale, percent and code memory
   always_ff @(posedge clock) begin
      if (accept && in_range && req_op == OP_CAL) begin
         cal_mem_ff[req_key_index] <= {req_cal_full, req_cal_percent, req_cal_code};
      end
      if (advance) begin
         cal_rd_ff <= cal_mem_ff[req_key_index];
      end
   end

   assign stage        = stage_ff;
   assign cal.baseline = base_rd_ff;
   assign cal.full     = cal_rd_ff[SAMPLE_W+PCT_W+CODE_W-1 -: SAMPLE_W];
   assign cal.percent  = cal_rd_ff[PCT_W+CODE_W-1 -: PCT_W];
   assign cal.code     = cal_rd_ff[CODE_W-1:0];

endmodule

// ===== rtl/core/akts_eval.sv =====
// threshold test, per-scan race tracking and result register
module akts_eval (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  akts_pkg::stage_type            stage,
   input  akts_pkg::cal_type              cal,
   input  akts_pkg::csr_type              csr,
   output logic                           rsp_valid,
   output logic [akts_pkg::CODE_W-1:0]    rsp_key_code,
   output logic [akts_pkg::SAMPLE_W-1:0]  rsp_level
);
   import akts_pkg::*;

   localparam logic signed [CMP_W-1:0] SCALE_S = CMP_W'(PCT_SCALE);

   logic signed [SAMPLE_W:0]   diff;
   logic signed [CMP_W-1:0]    lhs;
   logic signed [CMP_W-1:0]    rhs;
   logic [SPAN_W-1:0]          span;
   logic [PROD_W-1:0]          prod;
   logic                       pressed;
   logic                       is_sample;
   logic                       take_best;
   logic [SAMPLE_W-1:0]        best_level_ff, best_level_in, cand_level;
   logic [CODE_W-1:0]          best_code_ff, best_code_in, cand_code;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]          rsp_code_ff, rsp_code_in;
   logic [SAMPLE_W-1:0]        rsp_level_ff, rsp_level_in;

   // exact test: (sample - baseline) * 100 >= percent * span
   always_comb begin
      diff    = $signed({1'b0, stage.sample}) - $signed({1'b0, cal.baseline});
      span    = {{(SPAN_W-SAMPLE_W){1'b0}}, cal.full}
              - {{(SPAN_W-SAMPLE_W){1'b0}}, cal.baseline};
      lhs     = CMP_W'(diff) * SCALE_S;
      prod    = PROD_W'(cal.percent) * PROD_W'(span);
      rhs     = $signed({2'b00, prod});
      pressed = stage.in_range && (span != '0) && (lhs >= rhs);
   end

   // race winner update and result selection
   always_comb begin
      is_sample  = stage.valid && stage.op == OP_SAMPLE;
      take_best  = pressed && (stage.sample > best_level_ff);
      cand_level = take_best ? stage.sample : best_level_ff;
      cand_code  = take_best ? cal.code : best_code_ff;

      rsp_valid_in = 1'b0;
      rsp_code_in  = cal.code;
      rsp_level_in = stage.sample;
      if (is_sample) begin
         if (!csr.race_mode) begin
            rsp_valid_in = pressed;
         end else begin
            rsp_valid_in = stage.last && (cand_code != csr.no_key_code);
            rsp_code_in  = cand_code;
            rsp_level_in = cand_level;
         end
      end

      best_level_in = best_level_ff;
      best_code_in  = best_code_ff;
      if (is_sample) begin
         if (stage.last) begin
            best_level_in = '0;
            best_code_in  = csr.no_key_code;
         end else if (csr.race_mode) begin
            best_level_in = cand_level;
            best_code_in  = cand_code;
         end
      end
   end

   // race state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         best_level_ff <= '0;
         best_code_ff  <= NO_KEY_RESET;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         best_level_ff <= best_level_in;
         best_code_ff  <= best_code_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_code_ff  <= rsp_code_in;
         rsp_level_ff <= rsp_level_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_code_ff;
   assign rsp_level    = rsp_level_ff;

endmodule

// ===== rtl/core/akts_checker.sv =====
// port-level checker for the analog key threshold scanner, bound to the top
`include "analog_key_threshold_scanner_top_assert.svh"

module akts_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [akts_pkg::OP_W-1:0]          req_op,
   input logic [akts_pkg::KEY_W-1:0]         req_key_index,
   input logic [akts_pkg::SAMPLE_W-1:0]      req_sample,
   input logic                               req_last_in_scan,
   input logic [akts_pkg::SAMPLE_W-1:0]      req_cal_full,
   input logic [akts_pkg::PCT_W-1:0]         req_cal_percent,
   input logic [akts_pkg::CODE_W-1:0]        req_cal_code,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [akts_pkg::CODE_W-1:0]        rsp_key_code,
   input logic [akts_pkg::SAMPLE_W-1:0]      rsp_level,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [akts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input logic [akts_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import akts_pkg::*;

   // a stalled result stays valid
   `AKTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")

   // a stalled result keeps its payload
   `AKTS_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_key_code) && $stable(rsp_level), "stalled result changed")

   // requests are held back only by a stalled result
   `AKTS_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled without backpressure")

   // control writes are never refused
   `AKTS_ASSERT_NOW(a_csr_ready, 1'b1, csr_ready, "control write refused")

   // a new result follows an accepted request
   `AKTS_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without request")

endmodule

bind analog_key_threshold_scanner_top akts_checker u_akts_checker (.*);

// ===== verif/analog_key_threshold_scanner_top_tb.sv =====
// testbench for the analog key threshold scanner: directed and random requests against a predictor
module analog_key_threshold_scanner_top_tb;
   import akts_pkg::*;

   localparam int MAX_SAMPLE    = 2 ** SAMPLE_W - 1;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SHOWN_FAILS   = 10;

   // one request as the sender sees it
   typedef struct {
      op_type              op;
      logic [KEY_W-1:0]    key;
      logic [SAMPLE_W-1:0] sample;
      logic                last;
      logic [SAMPLE_W-1:0] cal_full;
      logic [PCT_W-1:0]    cal_percent;
      logic [CODE_W-1:0]   cal_code;
   } scan_req_type;

   // one reported key
   typedef struct {
      logic [CODE_W-1:0]   code;
      logic [SAMPLE_W-1:0] level;
   } key_report_type;

   // calibration tables, race state and the reports still owed by the block
   class key_report_board;
      logic [SAMPLE_W-1:0] baseline_tab [KEYS];
      logic [SAMPLE_W-1:0] full_tab [KEYS];
      logic [PCT_W-1:0]    percent_tab [KEYS];
      logic [CODE_W-1:0]   code_tab [KEYS];
      logic [SAMPLE_W-1:0] best_level;
      logic [CODE_W-1:0]   best_code;
      logic                race_mode;
      logic [CODE_W-1:0]   no_key_code;
      key_report_type      pending [$];
      int                  fail_count;

      function new();
         best_level  = '0;
         best_code   = NO_KEY_RESET;
         race_mode   = 1'b0;
         no_key_code = NO_KEY_RESET;
         fail_count  = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_RACE_MODE:   race_mode = data[0];
            CSR_NO_KEY_CODE: no_key_code = data[CODE_W-1:0];
            default: ;
         endcase
      endfunction

      // exact percent test, span taken modulo 2^16
      function bit crosses_threshold(int k, logic [SAMPLE_W-1:0] smp);
         longint rise;
         longint span;
         rise = longint'(smp) - longint'(baseline_tab[k]);
         span = (longint'(full_tab[k]) - longint'(baseline_tab[k])) & 64'hFFFF;
         if (span == 0) return 1'b0;
         return rise * PCT_SCALE >= longint'(percent_tab[k]) * span;
      endfunction

      function void note_request(scan_req_type r);
         bit             pressed;
         key_report_type hit;
         case (r.op)
            OP_BASELINE: baseline_tab[r.key] = r.sample;
            OP_CAL: begin
               full_tab[r.key]    = r.cal_full;
               percent_tab[r.key] = r.cal_percent;
               code_tab[r.key]    = r.cal_code;
            end
            OP_SAMPLE: begin
               pressed = crosses_threshold(int'(r.key), r.sample);
               if (!race_mode) begin
                  if (pressed) begin
                     hit.code  = code_tab[r.key];
                     hit.level = r.sample;
                     pending.push_back(hit);
                  end
               end else begin
                  // strictly higher sample wins, ties stay with the first
                  if (pressed && r.sample > best_level) begin
                     best_level = r.sample;
                     best_code  = code_tab[r.key];
                  end
                  if (r.last && best_code != no_key_code) begin
                     hit.code  = best_code;
                     hit.level = best_level;
                     pending.push_back(hit);
                  end
               end
               // scan end clears the race state in both modes
               if (r.last) begin
                  best_level = '0;
                  best_code  = no_key_code;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_report(logic [CODE_W-1:0] code, logic [SAMPLE_W-1:0] level);
         key_report_type want;
         if (pending.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_FAILS)
               $display("unexpected key report: code %0d level %0d", code, level);
            return;
         end
         want = pending.pop_front();
         if (want.code !== code || want.level !== level) begin
            fail_count++;
            if (fail_count <= SHOWN_FAILS)
               $display("key report mismatch: expected code %0d level %0d, got code %0d level %0d",
                        want.code, want.level, code, level);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [OP_W-1:0]        req_op = '0;
   logic [KEY_W-1:0]       req_key_index = '0;
   logic [SAMPLE_W-1:0]    req_sample = '0;
   logic                   req_last_in_scan = 1'b0;
   logic [SAMPLE_W-1:0]    req_cal_full = '0;
   logic [PCT_W-1:0]       req_cal_percent = '0;
   logic [CODE_W-1:0]      req_cal_code = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CODE_W-1:0]      rsp_key_code;
   logic [SAMPLE_W-1:0]    rsp_level;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   key_report_board board = new();

   // keys whose baseline and calibration are both written
   bit                base_done [KEYS];
   bit                cal_done [KEYS];
   bit                in_ready [KEYS];
   int                ready_keys [$];
   logic [CODE_W-1:0] nk_now = NO_KEY_RESET;

   // idling controls
   int gap_pct = 30;
   int stall_pct = 30;
   int burst_left = 0;
   int stall_run = 0;
   bit stall_hold = 1'b0;
   int cycle_count = 0;

   analog_key_threshold_scanner_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_key_index    (req_key_index),
      .req_sample       (req_sample),
      .req_last_in_scan (req_last_in_scan),
      .req_cal_full     (req_cal_full),
      .req_cal_percent  (req_cal_percent),
      .req_cal_code     (req_cal_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_code     (rsp_key_code),
      .rsp_level        (rsp_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result monitor and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_report(rsp_key_code, rsp_level);
      if (stall_run == 0) begin
         stall_hold = ($urandom_range(0, 99) < stall_pct);
         stall_run  = $urandom_range(1, 6);
      end
      stall_run--;
      rsp_stall <= stall_hold;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("analog_key_threshold_scanner_top regression: fail");
         $finish;
      end
   end

   // drive one request in bursts with random gaps, predict once accepted
   task automatic send_request(scan_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_op           <= r.op;
      req_key_index    <= r.key;
      req_sample       <= r.sample;
      req_last_in_scan <= r.last;
      req_cal_full     <= r.cal_full;
      req_cal_percent  <= r.cal_percent;
      req_cal_code     <= r.cal_code;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      if (r.op == OP_BASELINE) base_done[r.key] = 1'b1;
      if (r.op == OP_CAL) cal_done[r.key] = 1'b1;
      if (base_done[r.key] && cal_done[r.key] && !in_ready[r.key]) begin
         in_ready[r.key] = 1'b1;
         ready_keys.push_back(int'(r.key));
      end
   endtask

   task automatic send_fields(op_type op, int key, int smp, bit last, int full, int pct,
                              int code);
      scan_req_type r;
      r.op          = op;
      r.key         = KEY_W'(key);
      r.sample      = SAMPLE_W'(smp);
      r.last        = last;
      r.cal_full    = SAMPLE_W'(full);
      r.cal_percent = PCT_W'(pct);
      r.cal_code    = CODE_W'(code);
      send_request(r);
   endtask

   // drop valid and wait until every report is in and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both control registers back to back
   task automatic configure(logic race, logic [CODE_W-1:0] nk);
      csr_index_type         idx [2];
      logic [CSR_DATA_W-1:0] val [2];
      idx[0] = CSR_RACE_MODE;
      idx[1] = CSR_NO_KEY_CODE;
      val[0] = {{(CSR_DATA_W-1){1'b0}}, race};
      val[1] = nk;
      for (int i = 0; i < 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         board.write_register(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
      nk_now = nk;
   endtask

   function automatic scan_req_type random_request();
      scan_req_type r;
      r.op          = op_type'($urandom_range(0, 3));
      r.key         = KEY_W'($urandom_range(0, KEYS - 1));
      r.sample      = SAMPLE_W'($urandom_range(0, MAX_SAMPLE));
      r.last        = 1'($urandom_range(0, 1));
      r.cal_full    = SAMPLE_W'($urandom_range(0, MAX_SAMPLE));
      r.cal_percent = PCT_W'($urandom_range(0, 255));
      r.cal_code    = CODE_W'($urandom_range(0, 255));
      return r;
   endfunction

   // sample on a calibrated key, often near its travel range
   function automatic scan_req_type sample_request(bit last);
      scan_req_type r;
      int           k;
      int           lo;
      int           hi;
      int           v;
      r      = random_request();
      r.op   = OP_SAMPLE;
      k      = ready_keys[$urandom_range(0, ready_keys.size() - 1)];
      r.key  = KEY_W'(k);
      r.last = last;
      lo     = int'(board.baseline_tab[k]);
      hi     = int'(board.full_tab[k]);
      case ($urandom_range(0, 3))
         0: r.sample = SAMPLE_W'($urandom_range(0, MAX_SAMPLE));
         1: r.sample = (hi > lo) ? SAMPLE_W'($urandom_range(lo, hi))
                                 : SAMPLE_W'($urandom_range(0, MAX_SAMPLE));
         2: r.sample = $urandom_range(0, 1) ? SAMPLE_W'(MAX_SAMPLE) : SAMPLE_W'(MAX_SAMPLE / 2);
         default: begin
            v = lo + int'($urandom_range(0, 63)) - 8;
            if (v < 0) v = 0;
            if (v > MAX_SAMPLE) v = MAX_SAMPLE;
            r.sample = SAMPLE_W'(v);
         end
      endcase
      return r;
   endfunction

   function automatic scan_req_type baseline_request();
      scan_req_type r;
      r    = random_request();
      r.op = OP_BASELINE;
      if ($urandom_range(0, 1)) r.sample = SAMPLE_W'($urandom_range(0, 1023));
      return r;
   endfunction

   function automatic scan_req_type cal_request();
      scan_req_type r;
      r    = random_request();
      r.op = OP_CAL;
      if ($urandom_range(0, 9) < 6) r.cal_full = SAMPLE_W'($urandom_range(2048, MAX_SAMPLE));
      if ($urandom_range(0, 9) < 7) r.cal_percent = PCT_W'($urandom_range(0, 100));
      if ($urandom_range(0, 3) == 0) r.cal_code = nk_now;
      return r;
   endfunction

   // scans of random length, some without an end mark, with recalibration and noise
   task automatic run_scans(int count);
      scan_req_type r;
      int           sent;
      int           len;
      int           sel;
      bit           broken;
      sent = 0;
      while (sent < count) begin
         len    = $urandom_range(1, 8);
         broken = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < len; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
               send_request(baseline_request());
               sent++;
            end else if (sel < 16) begin
               send_request(cal_request());
               sent++;
            end else if (sel < 20) begin
               r    = random_request();
               r.op = OP_NONE;
               send_request(r);
            end else begin
               send_request(sample_request(i == len - 1 && !broken));
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic              race;
      logic [CODE_W-1:0] nk;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      configure(1'b0, NO_KEY_RESET);

      // calibrate four keys; end marks on these ops are ignored
      send_fields(OP_BASELINE, 0, 100, 1'b1, 0, 0, 0);
      send_fields(OP_CAL, 0, 0, 1'b1, 4095, 50, 8'h04);
      send_fields(OP_BASELINE, 63, 4095, 1'b0, 0, 0, 0);
      send_fields(OP_CAL, 63, 0, 1'b0, 4095, 255, 8'hFF);
      send_fields(OP_BASELINE, 21, 2000, 1'b0, 0, 0, 0);
      send_fields(OP_CAL, 21, 0, 1'b0, 1000, 0, 8'h15);
      send_fields(OP_BASELINE, 42, 0, 1'b0, 0, 0, 0);
      send_fields(OP_CAL, 42, 0, 1'b0, 10, 255, 8'h00);

      // normal mode: full press, at baseline, below baseline, zero span
      send_fields(OP_SAMPLE, 0, 4095, 1'b0, 0, 0, 0);
      send_fields(OP_SAMPLE, 0, 100, 1'b0, 0, 0, 0);
      send_fields(OP_SAMPLE, 0, 0, 1'b0, 0, 0, 0);
      send_fields(OP_SAMPLE, 63, 4095, 1'b0, 0, 0, 0);
      // wrapped span with zero percent, scan end in normal mode
      send_fields(OP_SAMPLE, 21, 2000, 1'b1, 0, 0, 0);
      send_fields(OP_SAMPLE, 21, 1999, 1'b0, 0, 0, 0);
      // threshold edges at the highest percent
      send_fields(OP_SAMPLE, 42, 26, 1'b0, 0, 0, 0);
      send_fields(OP_SAMPLE, 42, 25, 1'b0, 0, 0, 0);
      // unused op with an end mark does nothing
      send_fields(OP_NONE, 0, 4095, 1'b1, 4095, 255, 255);

      // race mode: tie, zero sample, ignored mark, winner at scan end
      settle();
      configure(1'b1, 8'h00);
      send_fields(OP_SAMPLE, 0, 3000, 1'b0, 0, 0, 0);
      send_fields(OP_SAMPLE, 42, 3000, 1'b0, 0, 0, 0);
      send_fields(OP_SAMPLE, 21, 0, 1'b0, 0, 0, 0);
      send_fields(OP_BASELINE, 21, 2000, 1'b1, 0, 0, 0);
      send_fields(OP_SAMPLE, 63, 4095, 1'b1, 0, 0, 0);
      // empty scan, then a winner carrying the no-key code
      send_fields(OP_SAMPLE, 42, 0, 1'b1, 0, 0, 0);
      send_fields(OP_SAMPLE, 42, 4095, 1'b1, 0, 0, 0);
      send_fields(OP_SAMPLE, 0, 4095, 1'b1, 0, 0, 0);

      // random phases across register settings and idling patterns
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               race = 1'b0; nk = 8'h00; gap_pct = 30; stall_pct = 30;
            end
            1: begin
               race = 1'b1; nk = 8'hFF; gap_pct = 50; stall_pct = 40;
            end
            2: begin
               race = 1'b1; nk = CODE_W'($urandom_range(1, 254)); gap_pct = 0; stall_pct = 0;
            end
            3: begin
               race = 1'b0; nk = 8'hFF; gap_pct = 20; stall_pct = 60;
            end
            default: begin
               race = 1'b1; nk = 8'h00; gap_pct = 70; stall_pct = 20;
            end
         endcase
         settle();
         configure(race, nk);
         run_scans(80);
      end

      settle();
      if (board.fail_count == 0 && board.pending.size() == 0)
         $display("analog_key_threshold_scanner_top regression: pass");
      else
         $display("analog_key_threshold_scanner_top regression: fail");
      $finish;
   end

endmodule
